>>> design/ehwm_pkg.sv
// ehwm_pkg: shared constants, register indexes, fsm and control types
// for the error history window matcher; no dependencies
package ehwm_pkg;

   // default build parameters
   localparam int DefWindowDepth = 16;
   localparam int DefMatchSlots  = 4;
   localparam int DefCodeBits    = 16;

   // fixed field widths
   localparam int RegCodes       = 4;
   localparam int CodeFieldBits  = 16;
   localparam int TimeBits       = 63;
   localparam int WindowSizeBits = 5;
   localparam int SetSizeBits    = 3;
   localparam int EntriesBits    = 5;
   localparam int CountBits      = 7;
   localparam int CsrDataBits    = 16;
   localparam int CsrIndexBits   = 3;

   // register indexes
   localparam logic [CsrIndexBits-1:0] CsrWindowSize = 3'd0;
   localparam logic [CsrIndexBits-1:0] CsrMatchA     = 3'd1;
   localparam logic [CsrIndexBits-1:0] CsrMatchB     = 3'd2;
   localparam logic [CsrIndexBits-1:0] CsrMatchC     = 3'd3;
   localparam logic [CsrIndexBits-1:0] CsrMatchD     = 3'd4;
   localparam logic [CsrIndexBits-1:0] CsrSetSize    = 3'd5;

   localparam logic [WindowSizeBits-1:0] WindowSizeReset = 5'd16;

   // request opcodes
   localparam logic OpAppend = 1'b0;
   localparam logic OpClear  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } ehwm_state_type;

   // control from the sequencer to the scan accumulator
   typedef struct packed {
      logic clear;
      logic rd_en;
      logic rd_first;
   } ehwm_scan_ctrl_type;

endpackage

>>> design/ehwm_ring_mem.sv
// ehwm_ring_mem: event ring storage, one write port and one registered read port
// no package dependencies
module ehwm_ring_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 79
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> design/ehwm_scan.sv
// ehwm_scan: per-entry match counting and first/last/oldest capture over a ring scan
// depends on ehwm_pkg
module ehwm_scan #(
   parameter int WINDOW_DEPTH = 16,
   parameter int ACTIVE_SLOTS = 4,
   parameter int CODE_W       = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ehwm_pkg::ehwm_scan_ctrl_type          ctrl,
   input  logic [CODE_W-1:0]                     rd_code,
   input  logic [ehwm_pkg::TimeBits-1:0]         rd_time,
   input  logic [CODE_W-1:0]                     match_code [ACTIVE_SLOTS],
   input  logic [$clog2(ACTIVE_SLOTS+1)-1:0]     act_slots,
   output logic [$clog2(WINDOW_DEPTH*ACTIVE_SLOTS+1)-1:0] match_count,
   output logic                                  first_valid,
   output logic [CODE_W-1:0]                     first_code,
   output logic [ehwm_pkg::TimeBits-1:0]         first_time,
   output logic                                  last_valid,
   output logic [CODE_W-1:0]                     last_code,
   output logic [ehwm_pkg::TimeBits-1:0]         last_time,
   output logic [ehwm_pkg::TimeBits-1:0]         oldest_time
);
   import ehwm_pkg::*;

   localparam int AW   = $clog2(ACTIVE_SLOTS + 1);
   localparam int CntW = $clog2(WINDOW_DEPTH * ACTIVE_SLOTS + 1);

   logic            vld_ff, vld_in;
   logic            first_ff, first_in;
   logic [AW-1:0]   hits;
   logic [CntW-1:0] count_ff, count_in;
   logic            fv_ff, fv_in, lv_ff, lv_in;
   logic [CODE_W-1:0]   fc_ff, fc_in, lc_ff, lc_in;
   logic [TimeBits-1:0] ft_ff, ft_in, lt_ff, lt_in, ot_ff, ot_in;

   // read data arrives in the cycle after the read is issued
   assign vld_in   = ctrl.rd_en;
   assign first_in = ctrl.rd_en & ctrl.rd_first;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= 1'b0;
         first_ff <= 1'b0;
      end else begin
         vld_ff   <= vld_in;
         first_ff <= first_in;
      end
   end

   // count active slots equal to this entry's code
   always_comb begin
      hits = '0;
      for (int j = 0; j < ACTIVE_SLOTS; j++) begin
         if (AW'(j) < act_slots && rd_code == match_code[j]) begin
            hits = hits + 1'b1;
         end
      end
   end

   // accumulate over the scan
   always_comb begin
      count_in = count_ff;
      fv_in    = fv_ff;
      fc_in    = fc_ff;
      ft_in    = ft_ff;
      lv_in    = lv_ff;
      lc_in    = lc_ff;
      lt_in    = lt_ff;
      ot_in    = ot_ff;
      if (ctrl.clear) begin
         count_in = '0;
         fv_in    = 1'b0;
         fc_in    = '0;
         ft_in    = '0;
         lv_in    = 1'b0;
         lc_in    = '0;
         lt_in    = '0;
         ot_in    = '0;
      end else if (vld_ff) begin
         count_in = count_ff + CntW'(hits);
         if (first_ff) begin
            ot_in = rd_time;
         end
         if (hits != '0) begin
            if (!fv_ff) begin
               fv_in = 1'b1;
               fc_in = rd_code;
               ft_in = rd_time;
            end
            lv_in = 1'b1;
            lc_in = rd_code;
            lt_in = rd_time;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         fv_ff    <= 1'b0;
         lv_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         fv_ff    <= fv_in;
         lv_ff    <= lv_in;
      end
   end

   always_ff @(posedge clock) begin
      fc_ff <= fc_in;
      ft_ff <= ft_in;
      lc_ff <= lc_in;
      lt_ff <= lt_in;
      ot_ff <= ot_in;
   end

   assign match_count = count_ff;
   assign first_valid = fv_ff;
   assign first_code  = fc_ff;
   assign first_time  = ft_ff;
   assign last_valid  = lv_ff;
   assign last_code   = lc_ff;
   assign last_time   = lt_ff;
   assign oldest_time = ot_ff;

endmodule

>>> design/error_history_window_matcher_unit.sv
// error_history_window_matcher_unit: top level, csr bank, ring pointers, sequencer
// depends on ehwm_pkg, ehwm_ring_mem, ehwm_scan
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   opcode, error_code, event_time
//   rsp      out        rsp_valid/rsp_stall   entries_held ... first_error_time
//   csr      in         csr_write             csr_index, csr_data
//
// an append steps through accept, one ring read per held entry, a drain state
// for the read latency and the result load; a clear goes from accept straight
// to the result load; the ring read port paces the scan of an append
// one request at a time; the next request is taken while a result waits
// a stalled result holds the sequencer in its load state until taken
// synchronous reset empties the window; the ring itself is not cleared
module error_history_window_matcher_unit #(
   parameter int WINDOW_DEPTH = ehwm_pkg::DefWindowDepth,
   parameter int MATCH_SLOTS  = ehwm_pkg::DefMatchSlots,
   parameter int CODE_BITS    = ehwm_pkg::DefCodeBits
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_opcode,
   input  logic [ehwm_pkg::CodeFieldBits-1:0]   req_error_code,
   input  logic [ehwm_pkg::TimeBits-1:0]        req_event_time,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ehwm_pkg::EntriesBits-1:0]     rsp_entries_held,
   output logic [ehwm_pkg::CountBits-1:0]       rsp_match_count,
   output logic                                 rsp_first_match_valid,
   output logic [ehwm_pkg::CodeFieldBits-1:0]   rsp_first_match_code,
   output logic [ehwm_pkg::TimeBits-1:0]        rsp_first_match_time,
   output logic                                 rsp_last_match_valid,
   output logic [ehwm_pkg::CodeFieldBits-1:0]   rsp_last_match_code,
   output logic [ehwm_pkg::TimeBits-1:0]        rsp_last_match_time,
   output logic [ehwm_pkg::TimeBits-1:0]        rsp_oldest_time,
   output logic [ehwm_pkg::TimeBits-1:0]        rsp_newest_time,
   output logic [ehwm_pkg::TimeBits-1:0]        rsp_first_error_time,
   input  logic                                 csr_write,
   input  logic [ehwm_pkg::CsrIndexBits-1:0]    csr_index,
   input  logic [ehwm_pkg::CsrDataBits-1:0]     csr_data
);
   import ehwm_pkg::*;

   localparam int SB        = CODE_BITS < CodeFieldBits ? CODE_BITS : CodeFieldBits;
   localparam int ActiveMax = MATCH_SLOTS < RegCodes ? MATCH_SLOTS : RegCodes;
   localparam int IW        = WINDOW_DEPTH > 1 ? $clog2(WINDOW_DEPTH) : 1;
   localparam int FW        = $clog2(WINDOW_DEPTH + 1);
   localparam int AW        = $clog2(ActiveMax + 1);
   localparam int CntW      = $clog2(WINDOW_DEPTH * ActiveMax + 1);
   localparam int EW        = FW > WindowSizeBits ? FW : WindowSizeBits;
   localparam int SW        = AW > SetSizeBits ? AW : SetSizeBits;
   localparam int MW        = SB + TimeBits;
   localparam logic [FW:0]   DepthSum = (FW+1)'(WINDOW_DEPTH);
   localparam logic [IW-1:0] LastIdx  = IW'(WINDOW_DEPTH - 1);

   // csr bank
   logic [WindowSizeBits-1:0] window_size_ff;
   logic [SB-1:0]             match_code_ff [ActiveMax];
   logic [SetSizeBits-1:0]    set_size_ff;
   logic [CsrIndexBits-1:0]   csr_slot;

   assign csr_slot = csr_index - CsrMatchA;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WindowSizeReset;
         set_size_ff    <= '0;
         for (int j = 0; j < ActiveMax; j++) begin
            match_code_ff[j] <= '0;
         end
      end else if (csr_write) begin
         case (csr_index)
            CsrWindowSize: begin
               window_size_ff <= csr_data[WindowSizeBits-1:0];
            end
            CsrMatchA, CsrMatchB, CsrMatchC, CsrMatchD: begin
               for (int j = 0; j < ActiveMax; j++) begin
                  if (csr_slot == CsrIndexBits'(j)) begin
                     match_code_ff[j] <= csr_data[SB-1:0];
                  end
               end
            end
            CsrSetSize: begin
               set_size_ff <= csr_data[SetSizeBits-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // active slot count, saturated to the slots built
   logic [AW-1:0] act_slots;
   assign act_slots = (SW'(set_size_ff) > SW'(ActiveMax)) ? AW'(ActiveMax)
                                                          : AW'(set_size_ff);

   // effective window, clamped to one .. depth
   logic [EW-1:0] ws_ext, eff_size;
   logic          window_full;
   always_comb begin
      ws_ext = EW'(window_size_ff);
      if (ws_ext == '0) begin
         eff_size = EW'(1);
      end else if (ws_ext > EW'(WINDOW_DEPTH)) begin
         eff_size = EW'(WINDOW_DEPTH);
      end else begin
         eff_size = ws_ext;
      end
   end

   // sequencer and ring pointers
   ehwm_state_type state_ff, state_in;
   logic [IW-1:0]  oldest_ff, oldest_in;
   logic [FW-1:0]  fill_ff, fill_in;
   logic [FW-1:0]  remain_ff, remain_in;
   logic [IW-1:0]  rd_addr_ff, rd_addr_in;
   logic [TimeBits-1:0] first_seen_ff, first_seen_in;
   logic [TimeBits-1:0] newest_ff, newest_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           accept;
   logic           out_free;
   logic           load;
   logic [FW:0]    wr_sum;
   logic [IW-1:0]  wr_addr;
   logic [IW-1:0]  oldest_inc;
   logic           wr_en;
   ehwm_scan_ctrl_type scan_ctrl;

   assign accept      = req_valid & ~req_stall;
   assign out_free    = ~rsp_valid_ff | ~rsp_stall;
   assign window_full = EW'(fill_ff) >= eff_size;
   assign wr_sum      = (FW+1)'(oldest_ff) + (FW+1)'(fill_ff);
   assign wr_addr     = (wr_sum >= DepthSum) ? IW'(wr_sum - DepthSum) : IW'(wr_sum);
   assign oldest_inc  = (oldest_ff == LastIdx) ? '0 : oldest_ff + 1'b1;
   assign wr_en       = accept & (req_opcode == OpAppend);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_opcode == OpClear) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (remain_ff == FW'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall          = 1'b1;
      load               = 1'b0;
      scan_ctrl.clear    = 1'b0;
      scan_ctrl.rd_en    = 1'b0;
      scan_ctrl.rd_first = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall       = 1'b0;
            scan_ctrl.clear = req_valid;
         end
         ST_SCAN: begin
            scan_ctrl.rd_en    = 1'b1;
            scan_ctrl.rd_first = (remain_ff == fill_ff);
         end
         ST_FINISH: begin
            load = out_free;
         end
         default: begin
         end
      endcase
   end

   // pointer and history update
   always_comb begin
      oldest_in     = oldest_ff;
      fill_in       = fill_ff;
      remain_in     = remain_ff;
      rd_addr_in    = rd_addr_ff;
      first_seen_in = first_seen_ff;
      newest_in     = newest_ff;
      if (accept) begin
         if (req_opcode == OpClear) begin
            oldest_in     = '0;
            fill_in       = '0;
            first_seen_in = '0;
            newest_in     = '0;
         end else begin
            if (window_full) begin
               oldest_in = oldest_inc;
            end else begin
               fill_in = fill_ff + 1'b1;
            end
            if (fill_ff == '0) begin
               first_seen_in = req_event_time;
            end
            newest_in  = req_event_time;
            rd_addr_in = window_full ? oldest_inc : oldest_ff;
            remain_in  = window_full ? fill_ff : fill_ff + 1'b1;
         end
      end else if (state_ff == ST_SCAN) begin
         rd_addr_in = (rd_addr_ff == LastIdx) ? '0 : rd_addr_ff + 1'b1;
         remain_in  = remain_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         oldest_ff     <= '0;
         fill_ff       <= '0;
         remain_ff     <= '0;
         rd_addr_ff    <= '0;
         first_seen_ff <= '0;
         newest_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         oldest_ff     <= oldest_in;
         fill_ff       <= fill_in;
         remain_ff     <= remain_in;
         rd_addr_ff    <= rd_addr_in;
         first_seen_ff <= first_seen_in;
         newest_ff     <= newest_in;
      end
   end

   // event ring
   logic [MW-1:0] rd_data;

   ehwm_ring_mem #(
      .DEPTH (WINDOW_DEPTH),
      .WIDTH (MW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_error_code[SB-1:0], req_event_time}),
      .rd_en   (scan_ctrl.rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   // match scan
   logic [CntW-1:0]     sc_count;
   logic                sc_fv, sc_lv;
   logic [SB-1:0]       sc_fc, sc_lc;
   logic [TimeBits-1:0] sc_ft, sc_lt, sc_ot;

   ehwm_scan #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .ACTIVE_SLOTS (ActiveMax),
      .CODE_W       (SB)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (scan_ctrl),
      .rd_code     (rd_data[MW-1:TimeBits]),
      .rd_time     (rd_data[TimeBits-1:0]),
      .match_code  (match_code_ff),
      .act_slots   (act_slots),
      .match_count (sc_count),
      .first_valid (sc_fv),
      .first_code  (sc_fc),
      .first_time  (sc_ft),
      .last_valid  (sc_lv),
      .last_code   (sc_lc),
      .last_time   (sc_lt),
      .oldest_time (sc_ot)
   );

   // result register
   logic [EntriesBits-1:0]   entries_ff;
   logic [CountBits-1:0]     count_ff;
   logic                     fv_ff, lv_ff;
   logic [CodeFieldBits-1:0] fc_ff, lc_ff;
   logic [TimeBits-1:0]      ft_ff, lt_ff, ot_ff, nt_ff, fe_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         entries_ff <= EntriesBits'(fill_ff);
         count_ff   <= CountBits'(sc_count);
         fv_ff      <= sc_fv;
         fc_ff      <= CodeFieldBits'(sc_fc);
         ft_ff      <= sc_ft;
         lv_ff      <= sc_lv;
         lc_ff      <= CodeFieldBits'(sc_lc);
         lt_ff      <= sc_lt;
         ot_ff      <= sc_ot;
         nt_ff      <= newest_ff;
         fe_ff      <= first_seen_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_entries_held      = entries_ff;
   assign rsp_match_count       = count_ff;
   assign rsp_first_match_valid = fv_ff;
   assign rsp_first_match_code  = fc_ff;
   assign rsp_first_match_time  = ft_ff;
   assign rsp_last_match_valid  = lv_ff;
   assign rsp_last_match_code   = lc_ff;
   assign rsp_last_match_time   = lt_ff;
   assign rsp_oldest_time       = ot_ff;
   assign rsp_newest_time       = nt_ff;
   assign rsp_first_error_time  = fe_ff;

   // checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(WINDOW_DEPTH))
      else $error("fill level beyond ring depth");

   a_oldest_bound: assert property (@(posedge clock) disable iff (reset)
      oldest_ff <= LastIdx)
      else $error("oldest pointer beyond ring");

   a_scan_remain: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> remain_ff != '0)
      else $error("scan running with no entries left");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside load state");

   a_match_flags: assert property (@(posedge clock) disable iff (reset)
      sc_fv == sc_lv)
      else $error("first and last match flags disagree");

endmodule

>>> tb/sv/error_history_window_matcher_unit_tb.sv
// error_history_window_matcher_unit_tb: self-checking bench for the error history
// window matcher; predicts each result from its own copy of the window and registers
// depends on ehwm_pkg and error_history_window_matcher_unit
module error_history_window_matcher_unit_tb;
   import ehwm_pkg::*;

   localparam int Depth      = DefWindowDepth;
   localparam int MatchSlots = DefMatchSlots;
   localparam int Phases     = 8;
   localparam int PhaseItems = 235;

   typedef struct packed {
      logic                     opcode;
      logic [CodeFieldBits-1:0] code;
      logic [TimeBits-1:0]      stamp;
   } error_event_type;

   typedef struct packed {
      logic [EntriesBits-1:0]   entries;
      logic [CountBits-1:0]     match_count;
      logic                     first_valid;
      logic [CodeFieldBits-1:0] first_code;
      logic [TimeBits-1:0]      first_stamp;
      logic                     last_valid;
      logic [CodeFieldBits-1:0] last_code;
      logic [TimeBits-1:0]      last_stamp;
      logic [TimeBits-1:0]      oldest_stamp;
      logic [TimeBits-1:0]      newest_stamp;
      logic [TimeBits-1:0]      first_error_stamp;
   } window_summary_type;

   typedef logic [TimeBits-1:0] summary_fields_type [11];

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_opcode = OpAppend;
   logic [CodeFieldBits-1:0] req_error_code = '0;
   logic [TimeBits-1:0]      req_event_time = '0;

   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [EntriesBits-1:0]   rsp_entries_held;
   logic [CountBits-1:0]     rsp_match_count;
   logic                     rsp_first_match_valid;
   logic [CodeFieldBits-1:0] rsp_first_match_code;
   logic [TimeBits-1:0]      rsp_first_match_time;
   logic                     rsp_last_match_valid;
   logic [CodeFieldBits-1:0] rsp_last_match_code;
   logic [TimeBits-1:0]      rsp_last_match_time;
   logic [TimeBits-1:0]      rsp_oldest_time;
   logic [TimeBits-1:0]      rsp_newest_time;
   logic [TimeBits-1:0]      rsp_first_error_time;

   logic                     csr_write = 1'b0;
   logic [CsrIndexBits-1:0]  csr_index = CsrWindowSize;
   logic [CsrDataBits-1:0]   csr_data = '0;

   // window and register copy used for prediction
   logic [CodeFieldBits-1:0] code_ring [Depth];
   logic [TimeBits-1:0]      stamp_ring [Depth];
   int unsigned              ring_head = 0;
   int unsigned              ring_fill = 0;
   logic [TimeBits-1:0]      first_error_seen = '0;
   logic [WindowSizeBits-1:0] cfg_window = WindowSizeReset;
   logic [CodeFieldBits-1:0] cfg_codes [RegCodes] = '{default: '0};
   logic [SetSizeBits-1:0]   cfg_set_size = '0;

   error_event_type    pending_events [$];
   window_summary_type expected_summaries [$];
   error_event_type    cur_event;
   logic [TimeBits-1:0] stamp_base = '0;

   int send_gap_pct = 0;
   int rsp_stall_pct = 0;
   int error_count = 0;
   int appends_sent = 0;
   int clears_sent = 0;
   int summaries_checked = 0;
   int matched_summaries = 0;

   string field_names [11] = '{"entries_held", "match_count", "first_match_valid",
      "first_match_code", "first_match_time", "last_match_valid", "last_match_code",
      "last_match_time", "oldest_time", "newest_time", "first_error_time"};

   error_history_window_matcher_unit dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_opcode            (req_opcode),
      .req_error_code        (req_error_code),
      .req_event_time        (req_event_time),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_entries_held      (rsp_entries_held),
      .rsp_match_count       (rsp_match_count),
      .rsp_first_match_valid (rsp_first_match_valid),
      .rsp_first_match_code  (rsp_first_match_code),
      .rsp_first_match_time  (rsp_first_match_time),
      .rsp_last_match_valid  (rsp_last_match_valid),
      .rsp_last_match_code   (rsp_last_match_code),
      .rsp_last_match_time   (rsp_last_match_time),
      .rsp_oldest_time       (rsp_oldest_time),
      .rsp_newest_time       (rsp_newest_time),
      .rsp_first_error_time  (rsp_first_error_time),
      .csr_write             (csr_write),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   // clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // apply one request to the window copy and work out the summary it produces
   function automatic window_summary_type record_event(input error_event_type ev);
      window_summary_type res;
      int unsigned limit, slots, k, j, s, hits, wr;
      res = '0;
      if (ev.opcode == OpClear) begin
         ring_head = 0;
         ring_fill = 0;
         first_error_seen = '0;
         return res;
      end
      limit = 32'(cfg_window);
      if (limit < 1) limit = 1;
      if (limit > Depth) limit = Depth;
      slots = (cfg_set_size > MatchSlots) ? MatchSlots : 32'(cfg_set_size);
      if (ring_fill == 0) first_error_seen = ev.stamp;
      wr = (ring_head + ring_fill) % Depth;
      code_ring[wr] = ev.code;
      stamp_ring[wr] = ev.stamp;
      // a full (or shrunk) window drops its oldest entry
      if (ring_fill >= limit) ring_head = (ring_head + 1) % Depth;
      else ring_fill++;
      // scan oldest to newest, one count per equal slot
      for (k = 0; k < ring_fill; k++) begin
         s = (ring_head + k) % Depth;
         hits = 0;
         for (j = 0; j < slots; j++)
            if (cfg_codes[j] == code_ring[s]) hits++;
         res.match_count = res.match_count + CountBits'(hits);
         if (hits != 0) begin
            if (!res.first_valid) begin
               res.first_valid = 1'b1;
               res.first_code = code_ring[s];
               res.first_stamp = stamp_ring[s];
            end
            res.last_valid = 1'b1;
            res.last_code = code_ring[s];
            res.last_stamp = stamp_ring[s];
         end
      end
      res.entries = EntriesBits'(ring_fill);
      res.oldest_stamp = stamp_ring[ring_head];
      res.newest_stamp = stamp_ring[(ring_head + ring_fill - 1) % Depth];
      res.first_error_stamp = first_error_seen;
      return res;
   endfunction

   function automatic summary_fields_type split_fields(input window_summary_type s);
      summary_fields_type f;
      f = '{s.entries, s.match_count, s.first_valid, s.first_code, s.first_stamp,
            s.last_valid, s.last_code, s.last_stamp, s.oldest_stamp, s.newest_stamp,
            s.first_error_stamp};
      return f;
   endfunction

   // request driver: the expectation is formed when a request is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_summaries.push_back(record_event(cur_event));
            if (cur_event.opcode == OpClear) clears_sent++;
            else appends_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_events.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
               cur_event = pending_events.pop_front();
               req_valid <= 1'b1;
               req_opcode <= cur_event.opcode;
               req_error_code <= cur_event.code;
               req_event_time <= cur_event.stamp;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor: compare each taken result with the oldest expectation
   always @(posedge clock) begin : check_results
      window_summary_type got, want;
      summary_fields_type got_f, want_f;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_entries_held, rsp_match_count, rsp_first_match_valid,
                    rsp_first_match_code, rsp_first_match_time, rsp_last_match_valid,
                    rsp_last_match_code, rsp_last_match_time, rsp_oldest_time,
                    rsp_newest_time, rsp_first_error_time};
            if (expected_summaries.size() == 0) begin
               $display("%0t: unexpected result, entries_held %0h", $time, rsp_entries_held);
               error_count++;
            end else begin
               want = expected_summaries.pop_front();
               want_f = split_fields(want);
               got_f = split_fields(got);
               for (int i = 0; i < 11; i++)
                  if (got_f[i] !== want_f[i]) begin
                     $display("%0t: %s expected %0h got %0h", $time, field_names[i],
                              want_f[i], got_f[i]);
                     error_count++;
                  end
               summaries_checked++;
               if (want.first_valid) matched_summaries++;
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   // register write, mirrored into the prediction copy
   task automatic write_reg(input logic [CsrIndexBits-1:0] idx,
                            input logic [CsrDataBits-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CsrWindowSize: cfg_window = value[WindowSizeBits-1:0];
         CsrMatchA:     cfg_codes[0] = value;
         CsrMatchB:     cfg_codes[1] = value;
         CsrMatchC:     cfg_codes[2] = value;
         CsrMatchD:     cfg_codes[3] = value;
         CsrSetSize:    cfg_set_size = value[SetSizeBits-1:0];
         default: ;
      endcase
   endtask

   task automatic queue_event(input logic op, input logic [CodeFieldBits-1:0] code,
                              input logic [TimeBits-1:0] stamp);
      error_event_type ev;
      ev.opcode = op;
      ev.code = code;
      ev.stamp = stamp;
      pending_events.push_back(ev);
   endtask

   task automatic wait_drained();
      while (pending_events.size() != 0 || req_valid || expected_summaries.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // mostly append runs on codes near the match set, some clears and wild values
   task automatic queue_random_events(input int count);
      logic [CodeFieldBits-1:0] code;
      logic [TimeBits-1:0] stamp;
      int pick;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 24) == 0) begin
            queue_event(OpClear, CodeFieldBits'($urandom), TimeBits'({$urandom, $urandom}));
         end else begin
            pick = $urandom_range(0, 9);
            if (pick < 5) code = cfg_codes[$urandom_range(0, RegCodes - 1)];
            else if (pick < 7) code = CodeFieldBits'($urandom_range(0, 3));
            else if (pick == 7) code = $urandom_range(0, 1) ? '1 : '0;
            else code = CodeFieldBits'($urandom);
            pick = $urandom_range(0, 9);
            if (pick < 8) begin
               stamp_base = stamp_base + TimeBits'($urandom_range(1, 1000));
               stamp = stamp_base;
            end else if (pick == 8) begin
               stamp = TimeBits'({$urandom, $urandom});
            end else begin
               stamp = $urandom_range(0, 1) ? '1 : '0;
            end
            queue_event(OpAppend, code, stamp);
         end
      end
   endtask

   // stimulus: directed checks, then random phases across settings and idling
   initial begin
      int window_plan [Phases] = '{16, 1, 0, 31, 5, 16, 3, 8};
      int set_plan [Phases] = '{4, 1, 0, 7, 2, 3, 4, 5};
      int send_plan [4] = '{0, 82, 0, 31};
      int stall_plan [4] = '{0, 0, 82, 31};
      logic [CodeFieldBits-1:0] code;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // default settings: empty match set
      @(negedge clock);
      queue_event(OpAppend, '0, '0);
      queue_event(OpAppend, '1, '1);
      wait_drained();

      // four-entry window, duplicate codes, oversized set size
      write_reg(CsrWindowSize, 16'd4);
      write_reg(CsrMatchA, 16'h0000);
      write_reg(CsrMatchB, 16'hFFFF);
      write_reg(CsrMatchC, 16'hFFFF);
      write_reg(CsrMatchD, 16'h1234);
      write_reg(CsrSetSize, 16'd7);
      @(negedge clock);
      queue_event(OpAppend, 16'h1234, 63'd5);
      queue_event(OpAppend, 16'h0000, 63'd0);
      queue_event(OpAppend, 16'hFFFF, '1);
      queue_event(OpAppend, 16'h7777, 63'd100);
      queue_event(OpAppend, 16'hFFFF, 63'd101);
      queue_event(OpAppend, 16'h0000, 63'd102);
      queue_event(OpClear, 16'hFFFF, '1);
      queue_event(OpClear, '0, '0);
      queue_event(OpAppend, 16'h7777, 63'd200);
      queue_event(OpAppend, 16'hFFFF, 63'd201);
      queue_event(OpAppend, 16'h1234, '1);
      queue_event(OpAppend, 16'h5555, 63'h2AAA_AAAA_AAAA_AAAA);
      queue_event(OpAppend, 16'hAAAA, 63'h5555_5555_5555_5555);
      queue_event(OpClear, '0, '0);
      queue_event(OpAppend, 16'h0000, 63'd7);
      wait_drained();

      // random phases; window changes without a clear exercise the shrink case
      for (int p = 0; p < Phases; p++) begin
         write_reg(CsrWindowSize, (p % 2) ? {11'($urandom), 5'(window_plan[p])}
                                          : CsrDataBits'(window_plan[p]));
         for (int j = 0; j < RegCodes; j++) begin
            if (p == 2) code = (j % 2) ? '1 : '0;
            else if (j > 0 && $urandom_range(0, 3) == 0) code = cfg_codes[j - 1];
            else code = CodeFieldBits'($urandom);
            write_reg(CsrMatchA + CsrIndexBits'(j), code);
         end
         write_reg(CsrSetSize, (p % 2) ? {13'($urandom), 3'(set_plan[p])}
                                       : CsrDataBits'(set_plan[p]));
         @(negedge clock);
         send_gap_pct = send_plan[p % 4];
         rsp_stall_pct = stall_plan[p % 4];
         queue_random_events(PhaseItems);
         wait_drained();
      end

      repeat (40) @(posedge clock);
      $display("run covered %0d appends and %0d clears over %0d register settings",
               appends_sent, clears_sent, Phases + 2);
      $display("%0d results checked, %0d of them with a matching entry",
               summaries_checked, matched_summaries);
      if (error_count == 0)
         $display("error_history_window_matcher_unit: match");
      else
         $display("error_history_window_matcher_unit: mismatch");
      $finish;
   end

   // run limit
   initial begin
      #8000000;
      $display("timeout with %0d requests still waiting for a result",
               expected_summaries.size());
      $display("error_history_window_matcher_unit: mismatch");
      $finish;
   end

endmodule
